[rtl/core/upl_pkg.sv]
// shared types and constants for the unique positional list
package upl_pkg;

    // default sizing of the list
    localparam int CAPACITY_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths of the channels
    localparam int KIND_W      = 3;
    localparam int IN_VALUE_W  = 32;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_READ   = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_DUP     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    // what every cell does on the commit edge
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    // control broadcast to the row of cells
    typedef struct packed {
        logic     load;
        t_cell_op op;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_COMMIT = 1'b1
    } t_state;

endpackage

[rtl/core/upl_ifs.sv]
// valid/ready channel interfaces for operations and results
interface upl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [upl_pkg::KIND_W-1:0]            kind;
    logic signed [upl_pkg::IN_VALUE_W-1:0] value_in;
    logic [upl_pkg::POS_W-1:0]             position;

    modport source (output valid, kind, value_in, position, input ready);
    modport sink (input valid, kind, value_in, position, output ready);
endinterface

interface upl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [upl_pkg::STATUS_W-1:0]          status;
    logic signed [upl_pkg::IN_VALUE_W-1:0] read_value;
    logic [upl_pkg::COUNT_OUT_W-1:0]       entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

[rtl/core/upl_cell.sv]
// one list slot: holds a word, compares it, shifts with its neighbors
module upl_cell #(
    parameter int INDEX = 0,
    parameter int VW    = 32,
    parameter int IW    = 6
) (
    input  logic                i_clk,
    input  upl_pkg::t_cell_ctl  i_ctl,
    input  logic [IW-1:0]       i_count,
    input  logic [IW-1:0]       i_pos,
    input  logic [IW-1:0]       i_at,
    input  logic [VW-1:0]       i_word,
    input  logic [VW-1:0]       i_prev,
    input  logic [VW-1:0]       i_next,
    output logic [VW-1:0]       o_word,
    output logic                o_hit,
    output logic [VW-1:0]       o_rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [VW-1:0] r_word;
    logic          r_hit;
    logic          r_sel;

    // capture compare and position select when a transaction is taken
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hit <= (MY_IDX < i_count) && (r_word == i_word);
            r_sel <= (MY_IDX == i_pos);
        end
    end

    // shift right on insert, left on remove
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            upl_pkg::CELL_INSERT: begin
                if (MY_IDX == i_at) begin
                    r_word <= i_word;
                end else if (MY_IDX > i_at) begin
                    r_word <= i_prev;
                end
            end
            upl_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_at) begin
                    r_word <= i_next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;
    assign o_rd   = r_sel ? r_word : '0;

endmodule

[rtl/core/upl_chain.sv]
// row of list cells with neighbor links and hit / read reduction
module upl_chain #(
    parameter int CAPACITY = 32,
    parameter int VW       = 32,
    parameter int IW       = 6
) (
    input  logic                i_clk,
    input  upl_pkg::t_cell_ctl  i_ctl,
    input  logic [IW-1:0]       i_count,
    input  logic [IW-1:0]       i_pos,
    input  logic [IW-1:0]       i_at,
    input  logic [VW-1:0]       i_word,
    output logic                o_dup,
    output logic [VW-1:0]       o_rd
);

    logic [VW-1:0] words [CAPACITY];
    logic [VW-1:0] rds   [CAPACITY];
    logic [CAPACITY-1:0] hits;

    // cells, each linked to its left and right neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VW-1:0] prev_word;
        logic [VW-1:0] next_word;

        if (g == 0) begin : g_head
            assign prev_word = words[g];
        end else begin : g_mid_l
            assign prev_word = words[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign next_word = words[g];
        end else begin : g_mid_r
            assign next_word = words[g+1];
        end

        upl_cell #(
            .INDEX (g),
            .VW    (VW),
            .IW    (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (i_count),
            .i_pos   (i_pos),
            .i_at    (i_at),
            .i_word  (i_word),
            .i_prev  (prev_word),
            .i_next  (next_word),
            .o_word  (words[g]),
            .o_hit   (hits[g]),
            .o_rd    (rds[g])
        );
    end

    // any held copy of the value, and the word at the read position
    always_comb begin
        o_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_rd = o_rd | rds[k];
        end
    end

    assign o_dup = |hits;

endmodule

[rtl/core/unique_positional_list.sv]
// top level of the unique positional list
//
// Keeps an ordered list of up to CAPACITY distinct words. The operation
// channel i_in carries kind, value_in and position; the result channel o_out
// returns status, read_value and entry_count, one result per operation.
// Each list slot is a cell of a row; on insert the cells at and after the
// position shift right by one, on remove they shift left, all at once.
// At the accept edge every cell registers whether it holds the new value
// and whether it sits at the position; the commit edge then moves the
// cells and loads the result register from the reduced bits. A new
// operation is taken only once the previous one has committed.
// The result register lets the next operation be taken while a result
// waits; if the receiver stalls, the commit step waits until the result
// register is free, so no result is lost. i_in.ready is low meanwhile.
// Reset empties the list (count zero) and drops any pending result; the
// slot contents are not cleared and are never read beyond the count.
module unique_positional_list #(
    parameter int CAPACITY    = upl_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = upl_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    upl_in_if.sink     i_in,
    upl_out_if.source  o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > upl_pkg::POS_W) ? CW : upl_pkg::POS_W;
    localparam int VW = VALUE_WIDTH;

    upl_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    upl_pkg::t_kind  r_kind;
    logic [VW-1:0]   r_word;
    logic [IW-1:0]   r_pos;

    logic                              r_out_valid, n_out_valid;
    upl_pkg::t_status                  r_status, n_status;
    logic [upl_pkg::IN_VALUE_W-1:0]    r_read_value, n_read_value;
    logic [upl_pkg::COUNT_OUT_W-1:0]   r_entry_count, n_entry_count;

    upl_pkg::t_cell_ctl cell_ctl;
    logic [IW-1:0]      cell_at;
    logic [IW-1:0]      cell_pos;
    logic [IW-1:0]      count_ext;
    logic [VW-1:0]      cell_word;
    logic [VW-1:0]      in_word;
    logic               dup;
    logic [VW-1:0]      rd_word;
    logic               in_take;
    logic               commit;

    assign in_take   = i_in.valid && i_in.ready;
    assign commit    = (r_state == upl_pkg::S_COMMIT) && (!r_out_valid || o_out.ready);
    assign in_word   = VW'(i_in.value_in);
    assign count_ext = IW'(r_count);
    assign cell_pos  = (r_state == upl_pkg::S_IDLE) ? IW'(i_in.position) : r_pos;
    assign cell_word = (r_state == upl_pkg::S_IDLE) ? in_word : r_word;

    upl_chain #(
        .CAPACITY (CAPACITY),
        .VW       (VW),
        .IW       (IW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (cell_ctl),
        .i_count (count_ext),
        .i_pos   (cell_pos),
        .i_at    (cell_at),
        .i_word  (cell_word),
        .o_dup   (dup),
        .o_rd    (rd_word)
    );

    // state and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= upl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // operation and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= upl_pkg::t_kind'(i_in.kind);
            r_word <= in_word;
            r_pos  <= IW'(i_in.position);
        end
        r_status      <= n_status;
        r_read_value  <= n_read_value;
        r_entry_count <= n_entry_count;
    end

    // sequencer: decide the operation outcome and drive the cells
    always_comb begin
        logic signed [VW-1:0] rd_signed;

        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_status      = r_status;
        n_read_value  = r_read_value;
        n_entry_count = r_entry_count;
        cell_ctl.load = in_take;
        cell_ctl.op   = upl_pkg::CELL_HOLD;
        cell_at       = count_ext;
        rd_signed     = rd_word;

        unique case (r_state)
            upl_pkg::S_IDLE: begin
                if (in_take) begin
                    n_state = upl_pkg::S_COMMIT;
                end
            end
            upl_pkg::S_COMMIT: begin
                if (commit) begin
                    n_state      = upl_pkg::S_IDLE;
                    n_out_valid  = 1'b1;
                    n_status     = upl_pkg::STAT_DONE;
                    n_read_value = '0;
                    unique case (r_kind)
                        upl_pkg::KIND_APPEND, upl_pkg::KIND_INSERT: begin
                            if (dup) begin
                                n_status = upl_pkg::STAT_DUP;
                            end else if (r_count >= CW'(CAPACITY)) begin
                                n_status = upl_pkg::STAT_FULL;
                            end else begin
                                cell_ctl.op = upl_pkg::CELL_INSERT;
                                if (r_kind == upl_pkg::KIND_INSERT && r_pos < count_ext) begin
                                    cell_at = r_pos;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        upl_pkg::KIND_READ: begin
                            if (r_pos < count_ext) begin
                                n_read_value = upl_pkg::IN_VALUE_W'(rd_signed);
                            end else begin
                                n_status = upl_pkg::STAT_MISSING;
                            end
                        end
                        upl_pkg::KIND_REMOVE: begin
                            if (r_pos < count_ext) begin
                                cell_ctl.op = upl_pkg::CELL_REMOVE;
                                cell_at     = r_pos;
                                n_count     = r_count - 1'b1;
                            end else begin
                                n_status = upl_pkg::STAT_MISSING;
                            end
                        end
                        upl_pkg::KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_entry_count = upl_pkg::COUNT_OUT_W'(n_count);
                end
            end
            default: begin
                n_state = upl_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready        = (r_state == upl_pkg::S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.read_value  = r_read_value;
    assign o_out.entry_count = r_entry_count;

`ifndef SYNTHESIS
    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a taken transaction moves the sequencer to commit
    a_take_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == upl_pkg::S_COMMIT))
        else $error("accepted operation not committed next");

    // a result appears only out of a commit
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == upl_pkg::S_COMMIT))
        else $error("result without commit");

    // a completed insert grows the list by exactly one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && cell_ctl.op == upl_pkg::CELL_INSERT) |=>
        (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");
`endif

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the unique positional list
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP      = upl_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASE_COUNT   = 3;

    // kind codes the block treats as no-ops
    localparam logic [upl_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [upl_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam logic signed [upl_pkg::IN_VALUE_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [upl_pkg::IN_VALUE_W-1:0] WORD_MIN = 32'sh80000000;

    typedef struct {
        logic [upl_pkg::KIND_W-1:0]            kind;
        logic signed [upl_pkg::IN_VALUE_W-1:0] value;
        logic [upl_pkg::POS_W-1:0]             pos;
        int                                    phase;
    } t_list_op;

    typedef struct {
        logic [upl_pkg::STATUS_W-1:0]          status;
        logic signed [upl_pkg::IN_VALUE_W-1:0] read_value;
        logic [upl_pkg::COUNT_OUT_W-1:0]       entry_count;
    } t_list_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    upl_in_if  in_bus ();
    upl_out_if out_bus ();

    unique_positional_list i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shadow copy of the list
    logic signed [upl_pkg::IN_VALUE_W-1:0] shadow_words [LIST_CAP];
    int                                    shadow_len = 0;

    t_list_op  pending_ops [$];
    t_list_res expected_results [$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    logic in_taken    = 1'b0;
    int   drive_phase = 0;

    // clock
    always #4 i_clk = ~i_clk;

    function automatic bit shadow_holds(logic signed [upl_pkg::IN_VALUE_W-1:0] v);
        for (int i = 0; i < shadow_len; i++) begin
            if (shadow_words[i] == v) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // apply one operation to the shadow list and return its result
    function automatic t_list_res shadow_apply(t_list_op op);
        t_list_res r;
        int        at;
        int        i;
        r.status     = upl_pkg::STAT_DONE;
        r.read_value = '0;
        case (op.kind)
            upl_pkg::KIND_APPEND, upl_pkg::KIND_INSERT: begin
                at = (op.kind == upl_pkg::KIND_APPEND) ? shadow_len : int'(op.pos);
                if (shadow_holds(op.value)) begin
                    r.status = upl_pkg::STAT_DUP;
                end else if (shadow_len >= LIST_CAP) begin
                    r.status = upl_pkg::STAT_FULL;
                end else begin
                    if (at > shadow_len) begin
                        at = shadow_len;
                    end
                    for (i = shadow_len; i > at; i--) begin
                        shadow_words[i] = shadow_words[i-1];
                    end
                    shadow_words[at] = op.value;
                    shadow_len++;
                end
            end
            upl_pkg::KIND_READ: begin
                if (int'(op.pos) < shadow_len) begin
                    r.read_value = shadow_words[op.pos];
                end else begin
                    r.status = upl_pkg::STAT_MISSING;
                end
            end
            upl_pkg::KIND_REMOVE: begin
                if (int'(op.pos) < shadow_len) begin
                    for (i = int'(op.pos); i + 1 < shadow_len; i++) begin
                        shadow_words[i] = shadow_words[i+1];
                    end
                    shadow_len--;
                end else begin
                    r.status = upl_pkg::STAT_MISSING;
                end
            end
            upl_pkg::KIND_CLEAR: begin
                shadow_len = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = shadow_len[upl_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic int send_idle_pct(int phase);
        case (phase)
            0:       return 26;
            1:       return 46;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct(int phase);
        case (phase)
            0:       return 46;
            1:       return 26;
            default: return 0;
        endcase
    endfunction

    task automatic queue_op(logic [upl_pkg::KIND_W-1:0] kind,
                            logic signed [upl_pkg::IN_VALUE_W-1:0] value,
                            logic [upl_pkg::POS_W-1:0] pos);
        t_list_op op;
        op.kind  = kind;
        op.value = value;
        op.pos   = pos;
        op.phase = 0;
        pending_ops.push_back(op);
    endtask

    // random list position in a range
    function automatic logic [upl_pkg::POS_W-1:0] rand_pos(int hi);
        return upl_pkg::POS_W'($urandom_range(0, hi));
    endfunction

    // value mostly from a small pool so duplicates are common
    function automatic logic signed [upl_pkg::IN_VALUE_W-1:0] noise_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return $signed($urandom_range(0, 23)) - 12;
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end
        return $signed($urandom);
    endfunction

    // driver: presents transactions and the receiver ready at the falling edge
    always @(negedge i_clk) begin : drive
        t_list_op nxt;
        if (!i_rst_n) begin
            in_bus.valid    <= 1'b0;
            in_bus.kind     <= '0;
            in_bus.value_in <= '0;
            in_bus.position <= '0;
            out_bus.ready   <= 1'b0;
        end else begin
            if (!in_bus.valid || in_taken) begin
                if (pending_ops.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(pending_ops[0].phase)) begin
                    nxt = pending_ops.pop_front();
                    in_bus.valid    <= 1'b1;
                    in_bus.kind     <= nxt.kind;
                    in_bus.value_in <= nxt.value;
                    in_bus.position <= nxt.pos;
                    drive_phase     <= nxt.phase;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
            out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct(drive_phase));
        end
    end

    // monitor: checks results and predicts accepted operations at the rising edge
    always @(posedge i_clk) begin : watch
        t_list_res want;
        t_list_op  op;
        cycle_count = cycle_count + 1;
        if (i_rst_n) begin
            // result transaction against the oldest prediction
            if (out_bus.valid && out_bus.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d read_value %0d entry_count %0d",
                           out_bus.status, out_bus.read_value, out_bus.entry_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_bus.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, out_bus.status);
                        fail_count++;
                    end
                    if (out_bus.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0d, actual %0d",
                               want.read_value, out_bus.read_value);
                        fail_count++;
                    end
                    if (out_bus.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, out_bus.entry_count);
                        fail_count++;
                    end
                end
            end
            // operation transaction feeds the shadow list
            if (in_bus.valid && in_bus.ready) begin
                op.kind  = in_bus.kind;
                op.value = in_bus.value_in;
                op.pos   = in_bus.position;
                op.phase = 0;
                expected_results.push_back(shadow_apply(op));
            end
        end
        in_taken <= i_rst_n && in_bus.valid && in_bus.ready;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit reached");
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic signed [upl_pkg::IN_VALUE_W-1:0] base;
        int                                    step;
        int                                    fill_n;
        int                                    tail_n;
        int                                    random_left;
        int                                    total;
        i_rst_n = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, duplicates, head and tail inserts, misses, no-op kinds
        queue_op(upl_pkg::KIND_READ, '0, '0);
        queue_op(upl_pkg::KIND_REMOVE, '0, '0);
        queue_op(upl_pkg::KIND_INSERT, 32'sd7, 6'd20);
        queue_op(upl_pkg::KIND_APPEND, WORD_MAX, '0);
        queue_op(upl_pkg::KIND_APPEND, WORD_MIN, '1);
        queue_op(upl_pkg::KIND_APPEND, '0, '0);
        queue_op(upl_pkg::KIND_APPEND, WORD_MAX, '0);
        queue_op(upl_pkg::KIND_INSERT, -1, '0);
        queue_op(upl_pkg::KIND_INSERT, 32'sd1, '1);
        queue_op(upl_pkg::KIND_INSERT, 32'sd5, 6'd2);
        queue_op(upl_pkg::KIND_INSERT, WORD_MIN, 6'd3);
        queue_op(upl_pkg::KIND_READ, '0, '0);
        queue_op(upl_pkg::KIND_READ, '0, 6'd5);
        queue_op(upl_pkg::KIND_READ, '0, 6'd6);
        queue_op(upl_pkg::KIND_READ, '0, '1);
        queue_op(upl_pkg::KIND_REMOVE, '0, '1);
        queue_op(upl_pkg::KIND_REMOVE, '0, '0);
        queue_op(upl_pkg::KIND_REMOVE, '0, 6'd4);
        queue_op(upl_pkg::KIND_READ, '0, '0);
        for (int k = int'(KIND_SPARE_FIRST); k <= int'(KIND_SPARE_LAST); k++) begin
            queue_op(k[upl_pkg::KIND_W-1:0], $signed($urandom), rand_pos(63));
        end
        queue_op(upl_pkg::KIND_CLEAR, WORD_MIN, '1);
        queue_op(upl_pkg::KIND_READ, '0, '0);

        // random: mostly fill runs of distinct values, the rest noise
        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            if ($urandom_range(0, 99) < 65) begin
                base   = $signed($urandom);
                step   = $urandom_range(1, 4096);
                fill_n = $urandom_range(12, 38);
                tail_n = $urandom_range(4, 12);
                queue_op(upl_pkg::KIND_CLEAR, $signed($urandom), rand_pos(63));
                for (int k = 0; k < fill_n; k++) begin
                    queue_op($urandom_range(0, 1) ? upl_pkg::KIND_INSERT
                                                  : upl_pkg::KIND_APPEND,
                             base + k * step, rand_pos(40));
                end
                // duplicate of a held value, possibly while full
                queue_op(upl_pkg::KIND_APPEND, base, rand_pos(63));
                for (int k = 0; k < tail_n; k++) begin
                    case ($urandom_range(0, 4))
                        0: queue_op(upl_pkg::KIND_READ, $signed($urandom), rand_pos(40));
                        1: queue_op(upl_pkg::KIND_REMOVE, $signed($urandom), rand_pos(40));
                        2: queue_op(upl_pkg::KIND_INSERT,
                                    base + $urandom_range(0, fill_n - 1) * step,
                                    rand_pos(63));
                        3: queue_op(upl_pkg::KIND_INSERT, base + (fill_n + k) * step,
                                    rand_pos(63));
                        default: queue_op(upl_pkg::KIND_READ, '0, rand_pos(63));
                    endcase
                end
                random_left -= fill_n + tail_n + 2;
            end else begin
                tail_n = $urandom_range(5, 20);
                for (int k = 0; k < tail_n; k++) begin
                    queue_op((($urandom_range(0, 99) < 5)
                                 ? upl_pkg::KIND_CLEAR
                                 : upl_pkg::KIND_W'($urandom_range(0, 7))),
                             noise_value(), rand_pos(63));
                end
                random_left -= tail_n;
            end
        end

        // split the run into idling phases
        total = pending_ops.size();
        for (int i = 0; i < total; i++) begin
            pending_ops[i].phase = (i * PHASE_COUNT) / total;
        end

        // wait until every transaction is sent and every result checked
        @(negedge i_clk);
        while (pending_ops.size() != 0 || in_bus.valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[unique_positional_list.f]
rtl/core/upl_pkg.sv
rtl/core/upl_ifs.sv
rtl/core/upl_cell.sv
rtl/core/upl_chain.sv
rtl/core/unique_positional_list.sv
tb/sv/testbench.sv
